// ===== hw/rtl/rfcl_pkg.sv =====
// ----------------------------------------------------------------------------
// rfcl_pkg
// Shared types and codes of the regrowth fuel class lookup block.
// ----------------------------------------------------------------------------
package rfcl_pkg;

  // Field widths fixed by the transaction format
  localparam int FIELD_BITS = 16;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS = 16;

  // Request kinds
  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MISSING_VALUE     = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ROWS_IN_USE       = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_COLS_IN_USE       = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_FIXED_MODE        = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_FIXED_FUEL_NUMBER = 3'd4;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NODATA    = 2'd1,
    STATUS_NOT_FOUND = 2'd2,
    STATUS_NEG_AGE   = 2'd3
  } status_t;

  typedef struct packed {
    logic                         req_type;
    logic [5:0]                   table_row;
    logic [6:0]                   table_col;
    logic signed [FIELD_BITS-1:0] table_value;
    logic signed [FIELD_BITS-1:0] stand_age;
    logic signed [FIELD_BITS-1:0] veg_class;
  } req_t;

  typedef struct packed {
    logic signed [FIELD_BITS-1:0] fuel_number;
    status_t                      status;
  } rsp_t;

  typedef struct packed {
    logic signed [FIELD_BITS-1:0] missing_value;
    logic [6:0]                   rows_in_use;
    logic [7:0]                   cols_in_use;
    logic                         fixed_mode;
    logic signed [FIELD_BITS-1:0] fixed_fuel_number;
  } cfg_t;

endpackage

// ===== hw/rtl/rfcl_table_mem.sv =====
// ----------------------------------------------------------------------------
// rfcl_table_mem
// Single write port, single registered read port table memory.
// ----------------------------------------------------------------------------
module rfcl_table_mem #(
  parameter int DEPTH = 8192,
  parameter int WIDTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hw/rtl/rfcl_lookup_seq.sv =====
// ----------------------------------------------------------------------------
// rfcl_lookup_seq
// Sequencer that walks the table rows through the single memory read port.
// ----------------------------------------------------------------------------
module rfcl_lookup_seq #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 128,
  parameter int KEEP_BITS = 16,
  localparam int AW = $clog2(MAX_ROWS * MAX_COLS)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  rfcl_pkg::cfg_t       cfg,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  rfcl_pkg::req_t       req_data,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output rfcl_pkg::rsp_t       rsp_data,
  output logic                 mem_wr_en,
  output logic [AW-1:0]        mem_wr_addr,
  output logic [KEEP_BITS-1:0] mem_wr_data,
  output logic [AW-1:0]        mem_rd_addr,
  input  logic [KEEP_BITS-1:0] mem_rd_data
);

  localparam int RCW = $clog2(MAX_ROWS + 1);
  localparam int CB = $clog2(MAX_COLS);
  localparam int FB = rfcl_pkg::FIELD_BITS;

  typedef enum logic [1:0] {
    IDLE,
    KEY,
    FUEL,
    FINISH
  } state_t;

  state_t               state;
  logic [AW-1:0]        base;
  logic [RCW-1:0]       row;
  logic signed [FB-1:0] age;
  logic signed [FB-1:0] cls;
  rfcl_pkg::rsp_t       res;

  logic                 accept;
  logic                 rsp_load;
  logic [RCW-1:0]       nrows;
  logic [CB-1:0]        last_col;
  logic [CB-1:0]        col_sel;
  logic signed [FB-1:0] word_val;
  logic                 match;
  logic                 last_row;

  assign req_stall = rst || (state != IDLE);
  assign accept = req_valid && !req_stall;
  assign rsp_load = (state == FINISH) && (!rsp_valid || !rsp_stall);

  // Clamp register settings to the table size, and the age to the last column in use
  always_comb begin
    if (32'(cfg.rows_in_use) > MAX_ROWS) begin
      nrows = RCW'(MAX_ROWS);
    end else begin
      nrows = RCW'(cfg.rows_in_use);
    end
    if (cfg.cols_in_use == 8'd0) begin
      last_col = '0;
    end else if (32'(cfg.cols_in_use) > MAX_COLS) begin
      last_col = CB'(MAX_COLS - 1);
    end else begin
      last_col = CB'(cfg.cols_in_use - 8'd1);
    end
    if (32'(age[FB-2:0]) > 32'(last_col)) begin
      col_sel = last_col;
    end else begin
      col_sel = CB'(age[FB-2:0]);
    end
  end

  assign word_val = FB'(signed'(mem_rd_data));
  assign match = (word_val == cls);
  assign last_row = (row == nrows - 1'b1);

  // Table writes go straight to memory on acceptance when row and column are in range
  always_comb begin
    mem_wr_en = accept && (req_data.req_type == rfcl_pkg::REQ_WRITE) &&
                (32'(req_data.table_row) < MAX_ROWS) &&
                (32'(req_data.table_col) < MAX_COLS);
    mem_wr_addr = AW'(32'(req_data.table_row) * MAX_COLS + 32'(req_data.table_col));
    mem_wr_data = KEEP_BITS'(req_data.table_value);
  end

  // Read address: key of the first row, then next key or the fuel column
  always_comb begin
    unique case (state)
      IDLE: mem_rd_addr = '0;
      KEY: begin
        if (match) begin
          mem_rd_addr = base + AW'(col_sel);
        end else begin
          mem_rd_addr = base + AW'(MAX_COLS);
        end
      end
      default: mem_rd_addr = base;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      rsp_valid <= 1'b0;
    end else begin
      // load the output register from the finished result, or drop it once taken
      if (rsp_load) begin
        rsp_valid <= 1'b1;
        rsp_data  <= res;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (accept) begin
            age  <= req_data.stand_age;
            cls  <= req_data.veg_class;
            base <= '0;
            row  <= '0;
            priority if (req_data.req_type == rfcl_pkg::REQ_WRITE) begin
              res.fuel_number <= '0;
              res.status      <= rfcl_pkg::STATUS_OK;
              state           <= FINISH;
            end else if (req_data.stand_age == cfg.missing_value) begin
              res.fuel_number <= cfg.missing_value;
              res.status      <= rfcl_pkg::STATUS_NODATA;
              state           <= FINISH;
            end else if (cfg.fixed_mode) begin
              res.fuel_number <= cfg.fixed_fuel_number;
              res.status      <= rfcl_pkg::STATUS_OK;
              state           <= FINISH;
            end else if (nrows == '0) begin
              res.fuel_number <= cfg.missing_value;
              res.status      <= rfcl_pkg::STATUS_NOT_FOUND;
              state           <= FINISH;
            end else begin
              state <= KEY;
            end
          end
        end
        KEY: begin
          if (match) begin
            if (age[FB-1]) begin
              res.fuel_number <= cfg.missing_value;
              res.status      <= rfcl_pkg::STATUS_NEG_AGE;
              state           <= FINISH;
            end else begin
              state <= FUEL;
            end
          end else if (last_row) begin
            res.fuel_number <= cfg.missing_value;
            res.status      <= rfcl_pkg::STATUS_NOT_FOUND;
            state           <= FINISH;
          end else begin
            // advance to the next row's key
            base <= base + AW'(MAX_COLS);
            row  <= row + 1'b1;
          end
        end
        FUEL: begin
          res.fuel_number <= word_val;
          res.status      <= rfcl_pkg::STATUS_OK;
          state           <= FINISH;
        end
        FINISH: begin
          // hold until the output register is free
          if (rsp_load) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/regrowth_fuel_class_lookup.sv =====
// ----------------------------------------------------------------------------
// regrowth_fuel_class_lookup
// Reclassifies raster cells into fuel model numbers from a regrowth table.
// ----------------------------------------------------------------------------
// One transaction at a time. A table write goes from acceptance straight to
// the result. A lookup that ends on the nodata age, fixed mode or an empty
// table also goes straight to the result; one that searches ends when the
// class is flagged as missing or the age as negative after the key reads, or
// after the fuel word is read, with key reads up to rows_in_use, clamped to
// MAX_ROWS. The search time is set by the single read port of the table
// memory: one row key is read and compared per cycle, and the fuel word costs
// one more read. A finished result waits in the output register, and the next
// transaction is taken while it waits. Configuration writes are taken in any
// cycle and must be made only while the block is idle. Table entries read
// before they are written return arbitrary values.
module regrowth_fuel_class_lookup #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 128,
  parameter int VALUE_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic [rfcl_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [rfcl_pkg::CFG_DATA_BITS-1:0]     cfg_data,
  input  logic                                   req_valid,
  output logic                                   req_stall,
  input  rfcl_pkg::req_t                         req_data,
  output logic                                   rsp_valid,
  input  logic                                   rsp_stall,
  output rfcl_pkg::rsp_t                         rsp_data
);

  // Stored words keep at most the width of the value fields
  localparam int KEEP_BITS = (VALUE_BITS < rfcl_pkg::FIELD_BITS) ?
                             VALUE_BITS : rfcl_pkg::FIELD_BITS;
  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW = $clog2(DEPTH);

  rfcl_pkg::cfg_t       cfg;
  logic                 mem_wr_en;
  logic [AW-1:0]        mem_wr_addr;
  logic [KEEP_BITS-1:0] mem_wr_data;
  logic [AW-1:0]        mem_rd_addr;
  logic [KEEP_BITS-1:0] mem_rd_data;

  // Configuration registers; unknown indexes drop the write
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.missing_value     <= -16'sd9999;
      cfg.rows_in_use       <= 7'd0;
      cfg.cols_in_use       <= 8'd128;
      cfg.fixed_mode        <= 1'b0;
      cfg.fixed_fuel_number <= 16'sd0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        rfcl_pkg::CFG_MISSING_VALUE:     cfg.missing_value     <= cfg_data;
        rfcl_pkg::CFG_ROWS_IN_USE:       cfg.rows_in_use       <= cfg_data[6:0];
        rfcl_pkg::CFG_COLS_IN_USE:       cfg.cols_in_use       <= cfg_data[7:0];
        rfcl_pkg::CFG_FIXED_MODE:        cfg.fixed_mode        <= cfg_data[0];
        rfcl_pkg::CFG_FIXED_FUEL_NUMBER: cfg.fixed_fuel_number <= cfg_data;
        default: ;
      endcase
    end
  end

  // Search sequencer: owns the handshakes, the row walk and the result register
  rfcl_lookup_seq #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .KEEP_BITS(KEEP_BITS)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req_data   (req_data),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp_data   (rsp_data),
    .mem_wr_en  (mem_wr_en),
    .mem_wr_addr(mem_wr_addr),
    .mem_wr_data(mem_wr_data),
    .mem_rd_addr(mem_rd_addr),
    .mem_rd_data(mem_rd_data)
  );

  // Regrowth table, row-major, key in column 0 of each row
  rfcl_table_mem #(
    .DEPTH(DEPTH),
    .WIDTH(KEEP_BITS)
  ) u_table (
    .clk    (clk),
    .wr_en  (mem_wr_en),
    .wr_addr(mem_wr_addr),
    .wr_data(mem_wr_data),
    .rd_addr(mem_rd_addr),
    .rd_data(mem_rd_data)
  );

endmodule
